@@ sv/lrf_pkg.sv @@
// Shared types, constants and arithmetic helpers for the LED ring fade block.
`default_nettype none

package lrf_pkg;

	localparam int COLOR_W = 24;
	localparam int POS_W   = 8;

	// Configuration register indexes
	localparam logic [1:0] REG_BLEND  = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_BRIGHT = 2'd2;
	localparam logic [1:0] REG_LIMIT  = 2'd3;

	localparam logic [8:0]  BLEND_MAX   = 9'd256;
	localparam logic [8:0]  BLEND_RST   = 9'd256;
	localparam logic [6:0]  OFFSET_RST  = 7'd0;
	localparam logic [7:0]  BRIGHT_RST  = 8'd255;
	localparam logic [13:0] LIMIT_RST   = 14'd9999;

	typedef struct packed {
		logic [8:0]  blend;
		logic [6:0]  offset;
		logic [7:0]  bright;
		logic [13:0] limit;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] target;
		logic [POS_W-1:0]   pos;
		logic               done;
	} item_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_BLEND,
		B_EST,
		B_SCALE,
		B_ACC,
		B_DIV,
		B_OUT
	} bstate_t;

	// old + floor((new - old) * k / 256), clamped to a byte
	function automatic logic [7:0] blend_ch(input logic [7:0] oldv, input logic [7:0] newv,
			input logic [8:0] k);
		logic signed [8:0]  diff;
		logic signed [18:0] prod;
		logic signed [10:0] step;
		logic signed [11:0] res;
		diff = $signed({1'b0, newv}) - $signed({1'b0, oldv});
		prod = diff * $signed({1'b0, k});
		step = 11'(prod >>> 8);
		res  = $signed({4'b0, oldv}) + 12'(step);
		if (res < 0) begin
			return 8'd0;
		end else if (res > 12'sd255) begin
			return 8'd255;
		end
		return res[7:0];
	endfunction

	// floor(x / 255), exact for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x >> 8) + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

@@ sv/lrf_front.sv @@
// Front end: accepts pixels, tracks ring position and frame end, reduces the rotation.
`default_nettype none

module lrf_front #(
	parameter int LED_COUNT = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lrf_pkg::COLOR_W-1:0]   target_color,
	input  wire logic [6:0]                    ring_offset,
	output logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] off_mod,
	output logic                               q_push,
	output lrf_pkg::item_t                     q_item,
	input  wire logic                          q_ready
);

	localparam int PW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int OFS  = LED_COUNT * ((64 + LED_COUNT - 1) / LED_COUNT);
	localparam int RSH  = 18;
	localparam int RECIP = ((1 << RSH) + LED_COUNT - 1) / LED_COUNT;

	logic [PW-1:0] pos_q;
	logic          last;
	logic [9:0]    v;
	logic [27:0]   mprod;
	logic [9:0]    v_q;
	logic [9:0]    quot_q;
	logic [17:0]   qn;
	logic [17:0]   rem;
	logic [PW-1:0] off_mod_q;

	assign last     = (pos_q == PW'(LED_COUNT - 1));
	assign in_stall = !q_ready;
	assign q_push   = in_valid && q_ready;

	always_comb begin
		q_item        = '0;
		q_item.target = target_color;
		q_item.pos    = lrf_pkg::POS_W'(pos_q);
		q_item.done   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= last ? '0 : pos_q + PW'(1);
		end
	end

	// offset mod LED_COUNT through a reciprocal, two register steps
	assign v     = 10'(OFS) + 10'($signed(ring_offset));
	assign mprod = 28'(v) * 28'(RECIP);
	assign qn    = 18'(quot_q) * 18'(LED_COUNT);
	assign rem   = 18'(v_q) - qn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= 10'(OFS);
			quot_q    <= 10'(OFS / LED_COUNT);
			off_mod_q <= '0;
		end else begin
			v_q       <= v;
			quot_q    <= mprod[27:RSH];
			off_mod_q <= rem[PW-1:0];
		end
	end

	assign off_mod = off_mod_q;

endmodule

`default_nettype wire

@@ sv/lrf_queue.sv @@
// Two-entry queue between the front end and the pixel engine.
`default_nettype none

module lrf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lrf_pkg::item_t  push_item,
	output logic                 ready,
	output logic                 valid,
	input  wire logic            pop,
	output lrf_pkg::item_t       head
);

	lrf_pkg::item_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push || pop == 1'b0 && !ready)
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0)
		else $error("queue popped while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count out of step");
`endif

endmodule

`default_nettype wire

@@ sv/lrf_back.sv @@
// Pixel engine: color store, blend, current estimate, frame brightness divide, result register.
`default_nettype none

module lrf_back #(
	parameter int LED_COUNT = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lrf_pkg::cfg_t               cfg,
	input  wire logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] off_mod,
	input  wire logic                        q_valid,
	input  wire lrf_pkg::item_t              q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [5:0]                       led_index,
	output logic [lrf_pkg::COLOR_W-1:0]      led_color,
	output logic                             frame_done,
	output logic [7:0]                       frame_brightness,
	output logic [15:0]                      frame_current
);

	localparam int PW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	lrf_pkg::bstate_t state_q, state_d;

	logic [lrf_pkg::COLOR_W-1:0] mem_q [LED_COUNT];
	logic [LED_COUNT-1:0]        vld_q;

	lrf_pkg::item_t              item_q;
	logic [lrf_pkg::COLOR_W-1:0] rd_q;
	logic                        rdv_q;
	logic [lrf_pkg::COLOR_W-1:0] color_q;
	logic [PW-1:0]               idx_q;
	logic [5:0]                  est_q;
	logic [13:0]                 prod_q;
	logic [15:0]                 sum_q;
	logic [15:0]                 total_q;
	logic [23:0]                 rem_q;
	logic [15:0]                 dsor_q;
	logic [7:0]                  quo_q;
	logic [2:0]                  cnt_q;

	logic                        out_valid_q;
	logic [5:0]                  led_index_q;
	logic [lrf_pkg::COLOR_W-1:0] led_color_q;
	logic                        frame_done_q;
	logic [7:0]                  frame_bright_q;
	logic [15:0]                 frame_cur_q;

	logic [8:0]                  k;
	logic [lrf_pkg::COLOR_W-1:0] oldc;
	logic [lrf_pkg::COLOR_W-1:0] newc;
	logic [PW:0]                 isum;
	logic [PW:0]                 iwrap;
	logic [9:0]                  csum;
	logic [15:0]                 x20;
	logic [15:0]                 nsum;
	logic                        over;
	logic [23:0]                 dsh;
	logic                        out_free;
	logic [8:0]                  ix9;

	// control decode
	logic mem_rd;
	logic mem_wr;
	logic div_go;
	logic out_ld;

	assign k     = (cfg.blend > lrf_pkg::BLEND_MAX) ? lrf_pkg::BLEND_MAX : cfg.blend;
	assign oldc  = rdv_q ? rd_q : '0;
	assign newc  = {lrf_pkg::blend_ch(oldc[23:16], item_q.target[23:16], k),
	                lrf_pkg::blend_ch(oldc[15:8], item_q.target[15:8], k),
	                lrf_pkg::blend_ch(oldc[7:0], item_q.target[7:0], k)};
	assign isum  = {1'b0, item_q.pos[PW-1:0]} + {1'b0, off_mod};
	assign iwrap = (isum >= (PW+1)'(LED_COUNT)) ? isum - (PW+1)'(LED_COUNT) : isum;
	assign csum  = 10'(color_q[23:16]) + 10'(color_q[15:8]) + 10'(color_q[7:0]);
	assign x20   = 16'({csum, 4'b0}) + 16'({csum, 2'b0});
	assign nsum  = sum_q + 16'(lrf_pkg::div255(16'(prod_q)));
	assign over  = nsum > 16'(cfg.limit);
	assign dsh   = 24'(dsor_q) << cnt_q;
	assign out_free = !out_valid_q || !out_stall;
	assign ix9   = 9'(idx_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrf_pkg::B_IDLE:  if (q_valid) state_d = lrf_pkg::B_BLEND;
			lrf_pkg::B_BLEND: state_d = lrf_pkg::B_EST;
			lrf_pkg::B_EST:   state_d = lrf_pkg::B_SCALE;
			lrf_pkg::B_SCALE: state_d = lrf_pkg::B_ACC;
			lrf_pkg::B_ACC:   state_d = (item_q.done && over) ? lrf_pkg::B_DIV : lrf_pkg::B_OUT;
			lrf_pkg::B_DIV:   if (cnt_q == 3'd0) state_d = lrf_pkg::B_OUT;
			lrf_pkg::B_OUT:   if (out_free) state_d = lrf_pkg::B_IDLE;
			default:          state_d = lrf_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		div_go = 1'b0;
		out_ld = 1'b0;
		unique case (state_q)
			lrf_pkg::B_IDLE:  mem_rd = q_valid;
			lrf_pkg::B_BLEND: mem_wr = 1'b1;
			lrf_pkg::B_DIV:   div_go = 1'b1;
			lrf_pkg::B_OUT:   out_ld = out_free;
			default: ;
		endcase
	end

	assign q_pop = mem_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrf_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// color store
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[item_q.pos[PW-1:0]] <= newc;
		end
		if (mem_rd) begin
			rd_q <= mem_q[q_item.pos[PW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (mem_wr) begin
				vld_q[item_q.pos[PW-1:0]] <= 1'b1;
			end
			if (mem_rd) begin
				rdv_q <= vld_q[q_item.pos[PW-1:0]];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (mem_rd) begin
			item_q <= q_item;
		end
		if (state_q == lrf_pkg::B_BLEND) begin
			color_q <= newc;
			idx_q   <= iwrap[PW-1:0];
		end
		if (state_q == lrf_pkg::B_EST) begin
			est_q <= 6'(lrf_pkg::div255(x20));
		end
		if (state_q == lrf_pkg::B_SCALE) begin
			prod_q <= 14'(est_q * cfg.bright);
		end
		if (state_q == lrf_pkg::B_ACC) begin
			total_q <= nsum;
			dsor_q  <= nsum;
			rem_q   <= 24'(cfg.bright * cfg.limit);
			cnt_q   <= 3'd7;
			quo_q   <= (item_q.done && !over) ? cfg.bright : 8'd0;
		end
		if (div_go) begin
			if (rem_q >= dsh) begin
				rem_q        <= rem_q - dsh;
				quo_q[cnt_q] <= 1'b1;
			end
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (state_q == lrf_pkg::B_ACC) begin
			sum_q <= item_q.done ? 16'd0 : nsum;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_ld) begin
			led_index_q    <= ix9[5:0];
			led_color_q    <= color_q;
			frame_done_q   <= item_q.done;
			frame_bright_q <= item_q.done ? quo_q : 8'd0;
			frame_cur_q    <= item_q.done ? total_q : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign led_index        = led_index_q;
	assign led_color        = led_color_q;
	assign frame_done       = frame_done_q;
	assign frame_brightness = frame_bright_q;
	assign frame_current    = frame_cur_q;

`ifndef ASSERT_OFF
	a_blend_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lrf_pkg::B_BLEND |-> $past(state_q) == lrf_pkg::B_IDLE)
		else $error("blend without a store read");
	a_div_over_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lrf_pkg::B_DIV |-> dsor_q > 16'(cfg.limit))
		else $error("divide entered with sum under limit");
	a_mid_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !frame_done_q |-> frame_bright_q == 8'd0 && frame_cur_q == 16'd0)
		else $error("frame fields set on a mid-frame beat");
	a_bright_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> frame_bright_q <= cfg.bright)
		else $error("frame brightness above nominal");
`endif

endmodule

`default_nettype wire

@@ sv/led_ring_fade_current_limit.sv @@
// Top level of the LED ring fade and current limit block with its register file.
`default_nettype none

// Takes one target color per input beat in ring order and returns one beat per pixel with
// the rotated LED index and the color blended toward the target; the last pixel of each
// frame of LED_COUNT pixels also carries the summed current estimate and the brightness to
// apply. Each pixel passes through the pixel engine in turn (store read, blend, estimate,
// scale, accumulate, result load); when the sum exceeds the limit, a frame's last pixel also
// goes through the one-bit-per-cycle brightness divide before the result load. The color
// store is cleared at reset through per-entry valid bits, so no clearing pass is needed. A
// two-entry queue and the result register let input and output stall independently.
module led_ring_fade_current_limit #(
	parameter int LED_COUNT = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [13:0]                 cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lrf_pkg::COLOR_W-1:0] target_color,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [5:0]                       led_index,
	output logic [lrf_pkg::COLOR_W-1:0]      led_color,
	output logic                             frame_done,
	output logic [7:0]                       frame_brightness,
	output logic [15:0]                      frame_current
);

	localparam int PW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	lrf_pkg::cfg_t  cfg_q;
	lrf_pkg::item_t push_item;
	lrf_pkg::item_t head;
	logic           push;
	logic           q_ready;
	logic           q_valid;
	logic           pop;
	logic [PW-1:0]  off_mod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend  <= lrf_pkg::BLEND_RST;
			cfg_q.offset <= lrf_pkg::OFFSET_RST;
			cfg_q.bright <= lrf_pkg::BRIGHT_RST;
			cfg_q.limit  <= lrf_pkg::LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lrf_pkg::REG_BLEND:  cfg_q.blend  <= cfg_data[8:0];
				lrf_pkg::REG_OFFSET: cfg_q.offset <= cfg_data[6:0];
				lrf_pkg::REG_BRIGHT: cfg_q.bright <= cfg_data[7:0];
				lrf_pkg::REG_LIMIT:  cfg_q.limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	lrf_front #(
		.LED_COUNT(LED_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.target_color(target_color),
		.ring_offset (cfg_q.offset),
		.off_mod     (off_mod),
		.q_push      (push),
		.q_item      (push_item),
		.q_ready     (q_ready)
	);

	lrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.ready    (q_ready),
		.valid    (q_valid),
		.pop      (pop),
		.head     (head)
	);

	lrf_back #(
		.LED_COUNT(LED_COUNT)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.off_mod         (off_mod),
		.q_valid         (q_valid),
		.q_item          (head),
		.q_pop           (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.led_index       (led_index),
		.led_color       (led_color),
		.frame_done      (frame_done),
		.frame_brightness(frame_brightness),
		.frame_current   (frame_current)
	);

endmodule

`default_nettype wire

@@ verif/led_ring_fade_current_limit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the LED ring fade block: random and corner pixels, checked per beat.
module led_ring_fade_current_limit_test;

	localparam int RING         = 64;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 40;

	typedef struct {
		logic [5:0]  index;
		logic [23:0] color;
		logic        done;
		logic [7:0]  bright;
		logic [15:0] amps;
	} led_beat_t;

	class led_scoreboard;
		logic [8:0]        blend;
		logic signed [6:0] offset;
		logic [7:0]        bright;
		logic [13:0]       limit;
		logic [23:0]       shown [RING];
		int                slot;
		logic [15:0]       amps;
		led_beat_t         due [$];
		int                errors;
		int                beats;
		int                frames;
		int                limited;

		function new();
			blend = lrf_pkg::BLEND_RST;
			offset = 0;
			bright = lrf_pkg::BRIGHT_RST;
			limit = lrf_pkg::LIMIT_RST;
			foreach (shown[i]) shown[i] = '0;
			slot = 0;
			amps = '0;
			errors = 0;
			beats = 0;
			frames = 0;
			limited = 0;
		endfunction

		// floor-weighted step toward the target, clamped to a byte
		function logic [7:0] mix(logic [7:0] was, logic [7:0] want, int k);
			int moved;
			moved = (int'(want) - int'(was)) * k;
			moved = int'(was) + (moved >>> 8);
			if (moved < 0) begin
				return 8'd0;
			end else if (moved > 255) begin
				return 8'd255;
			end
			return moved[7:0];
		endfunction

		function int draw(logic [23:0] c);
			int est;
			est = (20 * (int'(c[23:16]) + int'(c[15:8]) + int'(c[7:0]))) / 255;
			return (est * int'(bright)) / 255;
		endfunction

		function void note_pixel(logic [23:0] want);
			led_beat_t   e;
			logic [23:0] was;
			int          k;
			int          rot;
			was = shown[slot];
			k = (blend > 9'd256) ? 256 : int'(blend);
			e.color = {mix(was[23:16], want[23:16], k), mix(was[15:8], want[15:8], k),
				mix(was[7:0], want[7:0], k)};
			shown[slot] = e.color;
			rot = (slot + int'(offset)) % RING;
			if (rot < 0) rot += RING;
			e.index = rot[5:0];
			amps = amps + 16'(draw(e.color));
			e.done = (slot == RING - 1);
			e.bright = '0;
			e.amps = '0;
			if (e.done) begin
				e.amps = amps;
				if (amps > limit) begin
					e.bright = 8'((int'(bright) * int'(limit)) / int'(amps));
					limited++;
				end else begin
					e.bright = bright;
				end
				slot = 0;
				amps = '0;
			end else begin
				slot++;
			end
			due.push_back(e);
		endfunction

		function void compare(string field, logic [23:0] want, logic [23:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [5:0] index, logic [23:0] color, logic done,
				logic [7:0] br, logic [15:0] ma);
			led_beat_t e;
			if (due.size() == 0) begin
				$display("%0t: LED beat with nothing expected, expected none, got index %0d color %h",
					$time, index, color);
				errors++;
				return;
			end
			e = due.pop_front();
			beats++;
			if (e.done) frames++;
			compare("led_index", 24'(e.index), 24'(index));
			compare("led_color", e.color, color);
			compare("frame_done", 24'(e.done), 24'(done));
			compare("frame_brightness", 24'(e.bright), 24'(br));
			compare("frame_current", 24'(e.amps), 24'(ma));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] target_color;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  led_index;
	logic [23:0] led_color;
	logic        frame_done;
	logic [7:0]  frame_brightness;
	logic [15:0] frame_current;

	led_scoreboard sb;
	int            send_idle = 36;
	int            recv_idle = 71;
	bit            hold_req = 1'b0;
	bit            hold_done = 1'b0;
	int            quiet = 0;

	led_ring_fade_current_limit dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [23:0] pick_color();
		logic [23:0] c;
		c = 24'($urandom);
		case ($urandom_range(0, 3))
			0: c = c | 24'hC0C0C0;
			1: c = c & 24'h3F3F3F;
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_pixel(input logic [23:0] c);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_color <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pixel(c);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [8:0] k, input logic signed [6:0] off,
			input logic [7:0] br, input logic [13:0] lim);
		cfg_wr_en <= 1'b1;
		cfg_index <= lrf_pkg::REG_BLEND;
		cfg_data <= {5'd0, k};
		@(posedge clk);
		cfg_index <= lrf_pkg::REG_OFFSET;
		cfg_data <= {7'd0, off};
		@(posedge clk);
		cfg_index <= lrf_pkg::REG_BRIGHT;
		cfg_data <= {6'd0, br};
		@(posedge clk);
		cfg_index <= lrf_pkg::REG_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.blend = k;
		sb.offset = off;
		sb.bright = br;
		sb.limit = lim;
	endtask

	// receiver: random stall, with one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(led_index, led_color, frame_done, frame_brightness, frame_current);
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [23:0] corner [11];
		int          n;
		sb = new();
		corner = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAAAAAA,
			24'h555555, 24'h7F7F7F, 24'h808080, 24'h010101, 24'hFEFEFE};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = lrf_pkg::REG_BLEND;
		cfg_data = '0;
		in_valid = 1'b0;
		target_color = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner[i]) send_pixel(corner[i]);
		repeat (54) send_pixel(pick_color());

		for (int phase = 1; phase < 8; phase++) begin
			wait_drained();
			if (phase == 3) begin
				send_idle = 71;
				recv_idle = 36;
			end else if (phase == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (phase)
				1: apply_settings(9'd128, 7'sd5, 8'd200, 14'd1000);
				2: apply_settings(9'd0, -7'sd64, 8'd0, 14'd0);
				3: apply_settings(9'd511, 7'sd63, 8'd255, 14'd0);
				4: apply_settings(9'd1, -7'sd1, 8'd1, 14'd16383);
				5: apply_settings(9'd256, -7'sd63, 8'd255, 14'd1);
				6: apply_settings(9'($urandom_range(0, 256)), 7'(int'($urandom_range(0, 126)) - 63),
					8'($urandom), 14'($urandom_range(0, 4000)));
				default: apply_settings(9'd64, 7'sd17, 8'd128, 14'd500);
			endcase
			if (phase == 1) hold_req = 1'b1;
			n = $urandom_range(50, 75);
			repeat (n) send_pixel(pick_color());
		end

		wait_drained();
		repeat (SETTLE_WAIT) @(posedge clk);
		if (sb.due.size() != 0) begin
			$display("%0t: %0d LED beats expected but never seen", $time, sb.due.size());
			sb.errors += sb.due.size();
		end
		$display("Checked %0d pixels over %0d frames, %0d of them current-limited,",
			sb.beats, sb.frames, sb.limited);
		$display("across eight register settings and three stall mixes plus a long output hold.");
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
